// ===== src/spe_pkg.sv =====
// Shared widths, command and status types for the sparse polynomial evaluator.
package spe_pkg;

  localparam int COEF_W     = 32;
  localparam int EXP_W      = 8;
  localparam int SUM_W      = 48;
  localparam int PROD_W     = 64;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic load;
    logic mul_sq;
    logic mul_x;
    logic mul_c;
    logic wr_pow;
    logic idx_dec;
    logic add_prod;
    logic add_coef;
    logic emit;
  } spe_cmd_t;

  typedef struct packed {
    logic in_exp_zero;
    logic idx_zero;
    logic bit_set;
    logic last_term;
    logic out_busy;
  } spe_stat_t;

endpackage

// ===== src/spe_datapath.sv =====
// Datapath: shared multiplier, power and sum registers, and the result register.
module spe_datapath import spe_pkg::*; #(
  parameter int EXP_BITS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [COEF_W-1:0]     cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  spe_cmd_t              cmd,
  output spe_stat_t             stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int EXP_USED = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
  localparam int IDX_W    = (EXP_USED > 1) ? $clog2(EXP_USED) : 1;

  function automatic logic [IDX_W-1:0] top_bit(input logic [EXP_USED-1:0] e);
    logic [IDX_W-1:0] t;
    t = '0;
    for (int i = 0; i < EXP_USED; i++) begin
      if (e[i]) begin
        t = IDX_W'(i);
      end
    end
    return t;
  endfunction

  logic signed [COEF_W-1:0] x_r;
  logic signed [COEF_W-1:0] coef_r;
  logic [EXP_USED-1:0]      exp_r;
  logic                     last_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [COEF_W-1:0] pow_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     ovf_r;
  logic                     out_valid_r;
  logic [SUM_W-1:0]         out_value_r;
  logic                     out_ovf_r;

  logic [EXP_USED-1:0]      in_exp;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] shifted;
  logic                     pow_sat;
  logic [COEF_W-1:0]        pow_val;
  logic signed [PROD_W-1:0] term;
  logic [SUM_W+17-1:0]      sum_wide;
  logic                     sum_sat;
  logic [SUM_W-1:0]         sum_val;
  logic                     do_add;

  assign in_exp = in_tdata[COEF_W +: EXP_USED];

  always_comb begin
    mul_a = pow_r;
    mul_b = pow_r;
    if (cmd.mul_x) begin
      mul_b = x_r;
    end
    if (cmd.mul_c) begin
      mul_a = coef_r;
    end
  end

  assign prod_nxt = mul_a * mul_b;
  assign shifted  = prod_r >>> FRAC_BITS;

  assign pow_sat = ~((&shifted[PROD_W-1:COEF_W-1]) | ~(|shifted[PROD_W-1:COEF_W-1]));
  assign pow_val = pow_sat ? (shifted[PROD_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                                : {1'b0, {(COEF_W-1){1'b1}}})
                           : shifted[COEF_W-1:0];

  assign term = cmd.add_coef ? {{(PROD_W-COEF_W){coef_r[COEF_W-1]}}, coef_r} : shifted;
  assign sum_wide = {{17{sum_r[SUM_W-1]}}, sum_r} + {term[PROD_W-1], term};
  assign sum_sat  = ~((&sum_wide[SUM_W+16:SUM_W-1]) | ~(|sum_wide[SUM_W+16:SUM_W-1]));
  assign sum_val  = sum_sat ? (sum_wide[SUM_W+16] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}})
                            : sum_wide[SUM_W-1:0];
  assign do_add   = cmd.add_prod | cmd.add_coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        x_r <= cfg_wdata;
      end
      if (do_add) begin
        sum_r <= cmd.emit ? '0 : sum_val;
      end
      if (cmd.emit) begin
        ovf_r <= 1'b0;
      end else begin
        ovf_r <= ovf_r | (cmd.wr_pow & pow_sat) | (do_add & sum_sat);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coef_r <= in_tdata[COEF_W-1:0];
      exp_r  <= in_exp;
      last_r <= in_tlast;
      pow_r  <= x_r;
      idx_r  <= top_bit(in_exp);
    end else begin
      if (cmd.wr_pow) begin
        pow_r <= pow_val;
      end
      if (cmd.idx_dec) begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end
    if (cmd.mul_sq | cmd.mul_x | cmd.mul_c) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      out_value_r <= sum_val;
      out_ovf_r   <= ovf_r | sum_sat;
    end
  end

  assign stat.in_exp_zero = ~(|in_exp);
  assign stat.idx_zero    = (idx_r == '0);
  assign stat.bit_set     = exp_r[idx_r];
  assign stat.last_term   = last_r;
  assign stat.out_busy    = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ===== src/spe_ctrl.sv =====
// Controller state machine that sequences square-and-multiply and accumulation.
module spe_ctrl import spe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  spe_stat_t stat,
  output spe_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADD0 = 7'b0000010,
    S_SQ   = 7'b0000100,
    S_SQW  = 7'b0001000,
    S_XM   = 7'b0010000,
    S_XW   = 7'b0100000,
    S_CW   = 7'b1000000
  } spe_state_t;

  spe_state_t state_r;
  spe_state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_exp_zero ? S_ADD0 : S_SQ;
        end
      end
      S_ADD0: begin
        if (!(stat.last_term && stat.out_busy)) begin
          cmd.add_coef = 1'b1;
          cmd.emit     = stat.last_term;
          state_nxt    = S_IDLE;
        end
      end
      S_SQ: begin
        if (stat.idx_zero) begin
          cmd.mul_c = 1'b1;
          state_nxt = S_CW;
        end else begin
          cmd.mul_sq  = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_SQW;
        end
      end
      S_SQW: begin
        cmd.wr_pow = 1'b1;
        state_nxt  = stat.bit_set ? S_XM : S_SQ;
      end
      S_XM: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_XW;
      end
      S_XW: begin
        cmd.wr_pow = 1'b1;
        state_nxt  = S_SQ;
      end
      S_CW: begin
        if (!(stat.last_term && stat.out_busy)) begin
          cmd.add_prod = 1'b1;
          cmd.emit     = stat.last_term;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/sparse_polynomial_evaluator.sv =====
// Top level of the sparse polynomial evaluator.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: coef[31:0], exponent[39:32]; tlast: last_term
//   out_     master     tdata: value[47:0]; tuser: overflow
//   cfg_     write      wdata: x_value[31:0]
//
// A term with exponent zero only adds its coefficient. Otherwise x_value is squared once per
// exponent bit below the highest set bit and multiplied in again for each set bit below it,
// then multiplied by the coefficient, all on the single shared 32 by 32 multiplier.
// Reset clears the sum, the overflow flag, x_value and the result valid flag.
// A waiting result does not block the next transaction; only a last term stalls on it.
module sparse_polynomial_evaluator import spe_pkg::*; #(
  parameter int EXP_BITS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [COEF_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // coef, exponent
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value
  output logic                  out_tuser   // overflow
);

  spe_cmd_t  cmd;
  spe_stat_t stat;

  spe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spe_datapath #(
    .EXP_BITS  (EXP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/spe_checker.sv =====
// Port-level checker for the sparse polynomial evaluator, with its bind statement.
module spe_checker import spe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while a term is in progress");

  a_zero_exp_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && (in_tdata[39:32] == 8'd0) && !out_tvalid
    |-> ##2 out_tvalid)
    else $error("constant last term did not produce a result in time");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sparse_polynomial_evaluator spe_checker u_spe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sparse_polynomial_evaluator_test.sv =====
// Self-checking testbench for the sparse polynomial evaluator with a term-sum scoreboard.
module sparse_polynomial_evaluator_test;
  import spe_pkg::*;

  class poly_scoreboard;
    localparam int FRAC = 16;
    localparam longint Q32_MAX = 2147483647;
    localparam longint Q32_MIN = -longint'(2147483647) - 1;
    localparam longint Q48_MAX = (longint'(1) <<< 47) - 1;
    localparam longint Q48_MIN = -(longint'(1) <<< 47);

    typedef struct packed {
      logic [SUM_W-1:0] value;
      logic             ovf;
    } poly_value_t;

    logic signed [COEF_W-1:0] point;
    logic signed [SUM_W-1:0]  acc;
    bit                       acc_ovf;
    poly_value_t              value_q[$];
    int                       fail_count;

    function new();
      point = '0;
      acc = '0;
      acc_ovf = 1'b0;
      fail_count = 0;
    endfunction

    task report(input string what);
      fail_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function void load_point(input logic signed [COEF_W-1:0] x);
      point = x;
    endfunction

    function int pending();
      return value_q.size();
    endfunction

    function longint fix_mul(input longint a, input longint b);
      longint p;
      p = (a * b) >>> FRAC;
      if (p > Q32_MAX) begin
        acc_ovf = 1'b1;
        p = Q32_MAX;
      end else if (p < Q32_MIN) begin
        acc_ovf = 1'b1;
        p = Q32_MIN;
      end
      return p;
    endfunction

    function longint term_of(input longint coef, input logic [EXP_W-1:0] e);
      int top;
      longint r;
      if (e == '0) return coef;
      top = EXP_W - 1;
      while (!e[top]) top--;
      r = point;
      for (int i = top - 1; i >= 0; i--) begin
        r = fix_mul(r, r);
        if (e[i]) r = fix_mul(r, point);
      end
      return (coef * r) >>> FRAC;
    endfunction

    function void note_term(input logic signed [COEF_W-1:0] coef,
                            input logic [EXP_W-1:0] e, input logic last);
      longint s;
      s = longint'(acc) + term_of(longint'(coef), e);
      if (s > Q48_MAX) begin
        s = Q48_MAX;
        acc_ovf = 1'b1;
      end else if (s < Q48_MIN) begin
        s = Q48_MIN;
        acc_ovf = 1'b1;
      end
      acc = s[SUM_W-1:0];
      if (last) begin
        value_q.push_back('{value: acc, ovf: acc_ovf});
        acc = '0;
        acc_ovf = 1'b0;
      end
    endfunction

    task check_result(input logic [SUM_W-1:0] value, input logic ovf);
      poly_value_t want;
      if (value_q.size() == 0) begin
        report($sformatf("result %h/%b arrived with nothing expected", value, ovf));
      end else begin
        want = value_q.pop_front();
        if (value !== want.value)
          report($sformatf("value %h, expected %h", value, want.value));
        if (ovf !== want.ovf)
          report($sformatf("overflow %b, expected %b", ovf, want.ovf));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [COEF_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  poly_scoreboard sb = new();
  bit sender_steady = 1'b0;
  bit sink_steady = 1'b0;
  int hold_left = 0;
  int rand_terms = 0;

  sparse_polynomial_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // coef, exponent
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // value
    .out_tuser  (out_tuser)   // overflow
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_term($signed(in_tdata[COEF_W-1:0]), in_tdata[COEF_W +: EXP_W], in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready = 1'b0;
      end else if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  task automatic send_term(input logic [COEF_W-1:0] coef, input logic [EXP_W-1:0] e,
                           input logic last);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {e, coef};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_point(input logic [COEF_W-1:0] x);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = x;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.load_point(x);
  endtask

  function automatic logic [COEF_W-1:0] pick_point();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    if (r < 5) return 32'h1_0000 + $urandom_range(0, 32'h2000) - 32'h1000;
    if (r < 7) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0001_0000;
      2: return 32'hFFFF_0000;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      default: return 32'h0000_8000;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return EXP_W'($urandom_range(0, 7));
    if (r < 17) return EXP_W'($urandom_range(8, 31));
    return EXP_W'($urandom_range(0, 255));
  endfunction

  task automatic send_poly(input int n_terms);
    for (int i = 0; i < n_terms; i++) begin
      send_term(pick_coef(), pick_exponent(), i == n_terms - 1);
      rand_terms++;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_term(32'h0001_E240, 8'd0, 1'b0);
    send_term(32'h7FFF_FFFF, 8'd3, 1'b1);

    set_point(32'h0001_8000);
    send_term(32'h7FFF_FFFF, 8'd0, 1'b1);
    send_term(32'h8000_0000, 8'd0, 1'b1);
    send_term(32'h0001_0000, 8'd1, 1'b0);
    send_term(32'h0001_0000, 8'd2, 1'b0);
    send_term(32'h0001_0000, 8'd255, 1'b1);
    repeat (2) send_term(32'h7FFF_FFFF, 8'd200, 1'b0);
    send_term(32'h7FFF_FFFF, 8'd200, 1'b1);
    repeat (2) send_term(32'h8000_0000, 8'd200, 1'b0);
    send_term(32'h8000_0000, 8'd200, 1'b1);
    send_term(32'hFFFF_0000, 8'd7, 1'b0);
    send_term(32'h0002_0000, 8'h55, 1'b1);

    set_point(32'h8000_0000);
    send_term(32'h0001_0000, 8'd2, 1'b1);
    send_term(32'h0001_0000, 8'd1, 1'b1);
    send_term(32'h7FFF_FFFF, 8'hAA, 1'b1);

    set_point(32'h7FFF_FFFF);
    send_term(32'hFFFF_0000, 8'd3, 1'b1);

    set_point(32'h0000_C000);
    sender_steady = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 30; i++) send_poly(1);
    sender_steady = 1'b0;

    for (int phase = 0; rand_terms < 1250; phase++) begin
      int n_polys;
      set_point(pick_point());
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      n_polys = $urandom_range(10, 40);
      for (int p = 0; p < n_polys; p++) begin
        if ($urandom_range(0, 9) == 0) send_poly($urandom_range(12, 24));
        else send_poly($urandom_range(1, 6));
      end
    end

    drain();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/spe_pkg.sv
src/spe_datapath.sv
src/spe_ctrl.sv
src/sparse_polynomial_evaluator.sv
src/spe_checker.sv
tb/sparse_polynomial_evaluator_test.sv
